// File: hw/rtl/flat_json_key_value_extractor_core_assert.svh
// assertion helpers for the json key extractor
`ifndef FLAT_JSON_KEY_VALUE_EXTRACTOR_CORE_ASSERT_SVH
`define FLAT_JSON_KEY_VALUE_EXTRACTOR_CORE_ASSERT_SVH

// same-cycle implication, masked while reset is low
`define FJKE_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, masked while reset is low
`define FJKE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hw/rtl/fjke_pkg.sv
`timescale 1ns / 1ps
package fjke_pkg;

    // key storage
    localparam int KEY_MAX_BYTES = 16;
    localparam int KEY_IDX_W     = $clog2(KEY_MAX_BYTES);
    localparam int KEY_LEN_W     = 5;

    // configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 64;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_FIRST = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_NEXT  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_LEN   = 2'd2;

    // result codes
    localparam logic       KIND_VALUE   = 1'b0;
    localparam logic       KIND_STATUS  = 1'b1;
    localparam logic [1:0] ST_FOUND     = 2'd0;
    localparam logic [1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [1:0] ST_MALFORMED = 2'd2;

    // characters
    localparam logic [7:0] CH_QUOTE    = 8'h22;
    localparam logic [7:0] CH_BSLASH   = 8'h5C;
    localparam logic [7:0] CH_COLON    = 8'h3A;
    localparam logic [7:0] CH_COMMA    = 8'h2C;
    localparam logic [7:0] CH_RBRACE   = 8'h7D;
    localparam logic [7:0] CH_RBRACKET = 8'h5D;
    localparam logic [7:0] CH_SPACE    = 8'h20;
    localparam logic [7:0] CH_TAB      = 8'h09;
    localparam logic [7:0] CH_LF       = 8'h0A;
    localparam logic [7:0] CH_CR       = 8'h0D;
    localparam logic [7:0] CH_LOW_N    = 8'h6E;
    localparam logic [7:0] CH_LOW_R    = 8'h72;
    localparam logic [7:0] CH_LOW_T    = 8'h74;

    // queue between parser and output side
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);

    // one parsed byte worth of results: optional value byte, optional status
    typedef struct packed {
        logic       has_byte;
        logic [7:0] value_byte;
        logic       has_status;
        logic [1:0] status;
    } t_rec;

    function automatic logic is_ws(input logic [7:0] c);
        is_ws = (c == CH_SPACE) || (c == CH_TAB) || (c == CH_LF) || (c == CH_CR);
    endfunction

    function automatic logic is_delim(input logic [7:0] c);
        is_delim = (c == CH_COMMA) || (c == CH_RBRACE) || (c == CH_RBRACKET);
    endfunction

endpackage

// File: hw/rtl/fjke_if.sv
`timescale 1ns / 1ps
// text byte channel
interface fjke_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] text_byte;
    logic       end_of_text;

    modport source (output valid, output text_byte, output end_of_text, input ready);
    modport sink   (input valid, input text_byte, input end_of_text, output ready);
endinterface

// result channel
interface fjke_out_if;
    logic       valid;
    logic       ready;
    logic       result_kind;
    logic [7:0] value_byte;
    logic [1:0] status;
    logic       run_last;

    modport source (output valid, output result_kind, output value_byte,
                    output status, output run_last, input ready);
    modport sink   (input valid, input result_kind, input value_byte,
                    input status, input run_last, output ready);
endinterface

// File: hw/rtl/fjke_front.sv
`timescale 1ns / 1ps
module fjke_front import fjke_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    fjke_in_if.sink               i_in,
    input  logic                  i_q_full,
    output logic                  o_push,
    output t_rec                  o_rec
);

    localparam logic [3:0] MODE_OUTSIDE     = 4'd0;
    localparam logic [3:0] MODE_TOKEN       = 4'd1;
    localparam logic [3:0] MODE_TOKEN_ESC   = 4'd2;
    localparam logic [3:0] MODE_AFTER_TOKEN = 4'd3;
    localparam logic [3:0] MODE_AFTER_COLON = 4'd4;
    localparam logic [3:0] MODE_STR_VAL     = 4'd5;
    localparam logic [3:0] MODE_STR_ESC     = 4'd6;
    localparam logic [3:0] MODE_BARE        = 4'd7;
    localparam logic [3:0] MODE_BARE_TAIL   = 4'd8;
    localparam logic [3:0] MODE_DONE        = 4'd9;

    logic [CFG_DATA_W-1:0] r_key_first;
    logic [CFG_DATA_W-1:0] r_key_next;
    logic [KEY_LEN_W-1:0]  r_key_len;
    logic [3:0]            r_mode,    n_mode;
    logic                  r_match,   n_match;
    logic [KEY_LEN_W-1:0]  r_tok_len, n_tok_len;

    logic [8*KEY_MAX_BYTES-1:0] w_key;
    logic [7:0]                 w_key_byte;
    logic [7:0]                 w_c;
    logic                       w_accept;
    logic                       w_feed_ok;
    logic                       w_decided;
    logic [1:0]                 w_status;
    logic                       w_emit;
    logic [7:0]                 w_emit_byte;

    assign w_c        = i_in.text_byte;
    assign i_in.ready = !i_q_full;
    assign w_accept   = i_in.valid && !i_q_full;

    // key character at the current token position
    assign w_key      = {r_key_next, r_key_first};
    assign w_key_byte = w_key[{r_tok_len[KEY_IDX_W-1:0], 3'b000} +: 8];
    assign w_feed_ok  = r_match && (r_tok_len < r_key_len)
                     && (r_tok_len < KEY_LEN_W'(KEY_MAX_BYTES)) && (w_c == w_key_byte);

    // parser step for one byte
    always_comb begin
        n_mode      = r_mode;
        n_match     = r_match;
        n_tok_len   = r_tok_len;
        w_decided   = 1'b0;
        w_status    = ST_FOUND;
        w_emit      = 1'b0;
        w_emit_byte = w_c;

        unique case (r_mode)
            MODE_OUTSIDE: begin
                if (w_c == CH_QUOTE) begin
                    n_mode    = MODE_TOKEN;
                    n_tok_len = '0;
                    n_match   = 1'b1;
                end
            end
            MODE_TOKEN: begin
                if (w_c == CH_BSLASH) begin
                    n_mode = MODE_TOKEN_ESC;
                end else if (w_c == CH_QUOTE) begin
                    n_match = r_match && (r_tok_len == r_key_len);
                    n_mode  = MODE_AFTER_TOKEN;
                end else if (w_feed_ok) begin
                    n_tok_len = r_tok_len + 1'b1;
                end else begin
                    n_match = 1'b0;
                end
            end
            MODE_TOKEN_ESC: begin
                if (w_feed_ok) begin
                    n_tok_len = r_tok_len + 1'b1;
                end else begin
                    n_match = 1'b0;
                end
                n_mode = MODE_TOKEN;
            end
            MODE_AFTER_TOKEN: begin
                if (!is_ws(w_c)) begin
                    if (w_c == CH_COLON) begin
                        n_mode = MODE_AFTER_COLON;
                    end else if (w_c == CH_QUOTE) begin
                        n_mode    = MODE_TOKEN;
                        n_tok_len = '0;
                        n_match   = 1'b1;
                    end else begin
                        n_mode = MODE_OUTSIDE;
                    end
                end
            end
            MODE_AFTER_COLON: begin
                if (!is_ws(w_c)) begin
                    if (!r_match) begin
                        if (w_c == CH_QUOTE) begin
                            n_mode    = MODE_TOKEN;
                            n_tok_len = '0;
                            n_match   = 1'b1;
                        end else begin
                            n_mode = MODE_OUTSIDE;
                        end
                    end else if (w_c == CH_QUOTE) begin
                        n_mode = MODE_STR_VAL;
                    end else if (is_delim(w_c)) begin
                        w_decided = 1'b1;
                        w_status  = ST_MALFORMED;
                    end else begin
                        w_emit = 1'b1;
                        n_mode = MODE_BARE;
                    end
                end
            end
            MODE_STR_VAL: begin
                if (w_c == CH_BSLASH) begin
                    n_mode = MODE_STR_ESC;
                end else if (w_c == CH_QUOTE) begin
                    w_decided = 1'b1;
                end else begin
                    w_emit = 1'b1;
                end
            end
            MODE_STR_ESC: begin
                w_emit = 1'b1;
                if (w_c == CH_LOW_N) begin
                    w_emit_byte = CH_LF;
                end else if (w_c == CH_LOW_R) begin
                    w_emit_byte = CH_CR;
                end else if (w_c == CH_LOW_T) begin
                    w_emit_byte = CH_TAB;
                end
                n_mode = MODE_STR_VAL;
            end
            MODE_BARE: begin
                if (is_delim(w_c)) begin
                    w_decided = 1'b1;
                end else if (is_ws(w_c)) begin
                    n_mode = MODE_BARE_TAIL;
                end else begin
                    w_emit = 1'b1;
                end
            end
            MODE_BARE_TAIL: begin
                if (!is_ws(w_c)) begin
                    w_decided = 1'b1;
                    w_status  = is_delim(w_c) ? ST_FOUND : ST_MALFORMED;
                end
            end
            default: begin
            end
        endcase

        // end of text without a decision so far
        if (!w_decided && i_in.end_of_text && (n_mode != MODE_DONE)) begin
            w_decided = 1'b1;
            w_status  = ((n_mode == MODE_OUTSIDE) || (n_mode == MODE_AFTER_TOKEN))
                      ? ST_NOT_FOUND : ST_MALFORMED;
        end
        if (w_decided) begin
            n_mode = MODE_DONE;
        end
        // next text starts fresh
        if (i_in.end_of_text) begin
            n_mode    = MODE_OUTSIDE;
            n_match   = 1'b1;
            n_tok_len = '0;
        end
    end

    // record for the queue
    assign o_push           = w_accept && (w_emit || w_decided);
    assign o_rec.has_byte   = w_emit;
    assign o_rec.value_byte = w_emit_byte;
    assign o_rec.has_status = w_decided;
    assign o_rec.status     = w_status;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_first <= '0;
            r_key_next  <= '0;
            r_key_len   <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_KEY_FIRST: r_key_first <= i_cfg_data;
                CFG_KEY_NEXT:  r_key_next  <= i_cfg_data;
                CFG_KEY_LEN:   r_key_len   <= i_cfg_data[KEY_LEN_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // parser state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode    <= MODE_OUTSIDE;
            r_match   <= 1'b1;
            r_tok_len <= '0;
        end else if (w_accept) begin
            r_mode    <= n_mode;
            r_match   <= n_match;
            r_tok_len <= n_tok_len;
        end
    end

endmodule

// File: hw/rtl/fjke_fifo.sv
`timescale 1ns / 1ps
module fjke_fifo import fjke_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_rec i_rec,
    input  logic i_pop,
    output logic o_full,
    output logic o_empty,
    output t_rec o_head
);

    t_rec                r_mem [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0] r_wr;
    logic [FIFO_PTR_W-1:0] r_rd;
    logic [FIFO_PTR_W:0]   r_cnt;

    assign o_full  = (r_cnt == (FIFO_PTR_W+1)'(FIFO_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_head  = r_mem[r_rd];

    // storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_rec;
        end
    end

    // pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

// File: hw/rtl/fjke_back.sv
`timescale 1ns / 1ps
module fjke_back import fjke_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_empty,
    input  t_rec       i_head,
    output logic       o_pop,
    fjke_out_if.source o_out
);

    logic r_phase;
    logic w_show_status;
    logic w_beat;

    // status beat once the value byte of this record is gone
    assign w_show_status = r_phase || !i_head.has_byte;

    assign o_out.valid       = !i_empty;
    assign o_out.result_kind = w_show_status ? KIND_STATUS : KIND_VALUE;
    assign o_out.value_byte  = w_show_status ? 8'h00 : i_head.value_byte;
    assign o_out.status      = w_show_status ? i_head.status : ST_FOUND;
    assign o_out.run_last    = w_show_status || !i_head.has_status;

    assign w_beat = o_out.valid && o_out.ready;
    assign o_pop  = w_beat && (w_show_status || !i_head.has_status);

    // remembers a value byte sent ahead of its status
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= 1'b0;
        end else if (w_beat) begin
            r_phase <= !o_pop;
        end
    end

endmodule

// File: hw/rtl/flat_json_key_value_extractor_core.sv
`timescale 1ns / 1ps
// channel   dir  beat contents
// i_in      in   text_byte, end_of_text
// o_out     out  result_kind, value_byte, status, run_last
// cfg       in   i_cfg_we, i_cfg_idx, i_cfg_data (write only)
//
// one text byte is taken per cycle while the queue is not full; the parser updates its state in that cycle
// a byte that yields a value byte and a status gives a value beat and then a status beat,
// so the sustained rate is set by the output side draining the 4-deep queue
// i_in.ready drops only while the queue is full; o_out stalls hold the queue head
// synchronous active-low reset clears key registers, parser state and queue
module flat_json_key_value_extractor_core import fjke_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    fjke_in_if.sink               i_in,
    fjke_out_if.source            o_out
);

`include "flat_json_key_value_extractor_core_assert.svh"

    logic w_push;
    logic w_pop;
    logic w_full;
    logic w_empty;
    t_rec w_rec;
    t_rec w_head;

    // parser
    fjke_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in       (i_in),
        .i_q_full   (w_full),
        .o_push     (w_push),
        .o_rec      (w_rec)
    );

    // result queue
    fjke_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_rec   (w_rec),
        .i_pop   (w_pop),
        .o_full  (w_full),
        .o_empty (w_empty),
        .o_head  (w_head)
    );

    // output sequencer
    fjke_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_empty (w_empty),
        .i_head  (w_head),
        .o_pop   (w_pop),
        .o_out   (o_out)
    );

    // checks
    `FJKE_ASSERT_NOW(a_no_push_full, i_clk, i_rst_n, w_push, !w_full,
        "record pushed into a full queue")
    `FJKE_ASSERT_NOW(a_status_last, i_clk, i_rst_n,
        o_out.valid && (o_out.result_kind == KIND_STATUS), o_out.run_last,
        "status beat without run_last")
    `FJKE_ASSERT_NEXT(a_status_follows, i_clk, i_rst_n,
        o_out.valid && o_out.ready && !o_out.run_last,
        o_out.valid && (o_out.result_kind == KIND_STATUS),
        "value byte not followed by its status")

endmodule

// File: tb/tb_flat_json_key_value_extractor_core.sv
`timescale 1ns / 1ps
module tb_flat_json_key_value_extractor_core;
    import fjke_pkg::*;

    localparam int SETTLE_CYCLES = 16;
    localparam int PHASES        = 8;
    localparam int PHASE_BYTES   = 190;

    // parser modes of the lookup predictor
    typedef enum logic [3:0] {
        PM_OUTSIDE, PM_TOKEN, PM_TOKEN_ESC, PM_AFTER_TOKEN, PM_AFTER_COLON,
        PM_STR_VAL, PM_STR_ESC, PM_BARE, PM_BARE_TAIL, PM_DONE
    } t_pmode;

    typedef struct packed {
        logic       kind;
        logic [7:0] vbyte;
        logic [1:0] st;
        logic       last;
    } t_res;

    // how a directed row is checked
    localparam logic [1:0] CHK_MODEL  = 2'd0;
    localparam logic [1:0] CHK_QUIET  = 2'd1;
    localparam logic [1:0] CHK_STATUS = 2'd2;

    typedef struct packed {
        logic [7:0] ch;
        logic       eot;
        logic [1:0] chk;
        logic [1:0] st;
    } t_row;

    localparam int DIR_ROWS = 43;

    // directed texts, empty key as left by reset
    t_row dir_tab [DIR_ROWS] = '{
        // text ending outside strings, both byte extremes
        '{8'h00,     1'b1, CHK_STATUS, ST_NOT_FOUND},
        '{8'hFF,     1'b1, CHK_STATUS, ST_NOT_FOUND},
        // empty token matches, bare value opens with a delimiter, then ignored bytes
        '{CH_QUOTE,  1'b0, CHK_QUIET,  ST_FOUND},
        '{CH_QUOTE,  1'b0, CHK_QUIET,  ST_FOUND},
        '{CH_COLON,  1'b0, CHK_QUIET,  ST_FOUND},
        '{CH_COMMA,  1'b0, CHK_STATUS, ST_MALFORMED},
        '{"x",       1'b0, CHK_QUIET,  ST_FOUND},
        '{"y",       1'b1, CHK_QUIET,  ST_FOUND},
        // string value with the n, t, r and quote escapes, closed on the end-of-text byte
        '{CH_QUOTE,  1'b0, CHK_QUIET,  ST_FOUND},
        '{CH_QUOTE,  1'b0, CHK_QUIET,  ST_FOUND},
        '{CH_SPACE,  1'b0, CHK_QUIET,  ST_FOUND},
        '{CH_COLON,  1'b0, CHK_QUIET,  ST_FOUND},
        '{CH_QUOTE,  1'b0, CHK_QUIET,  ST_FOUND},
        '{CH_BSLASH, 1'b0, CHK_QUIET,  ST_FOUND},
        '{CH_LOW_N,  1'b0, CHK_MODEL,  ST_FOUND},
        '{CH_BSLASH, 1'b0, CHK_QUIET,  ST_FOUND},
        '{CH_LOW_T,  1'b0, CHK_MODEL,  ST_FOUND},
        '{CH_BSLASH, 1'b0, CHK_QUIET,  ST_FOUND},
        '{CH_LOW_R,  1'b0, CHK_MODEL,  ST_FOUND},
        '{CH_BSLASH, 1'b0, CHK_QUIET,  ST_FOUND},
        '{CH_QUOTE,  1'b0, CHK_MODEL,  ST_FOUND},
        '{8'hFF,     1'b0, CHK_MODEL,  ST_FOUND},
        '{CH_QUOTE,  1'b1, CHK_STATUS, ST_FOUND},
        // bare value, whitespace, then a non-delimiter
        '{CH_QUOTE,  1'b0, CHK_QUIET,  ST_FOUND},
        '{CH_QUOTE,  1'b0, CHK_QUIET,  ST_FOUND},
        '{CH_COLON,  1'b0, CHK_QUIET,  ST_FOUND},
        '{"7",       1'b0, CHK_MODEL,  ST_FOUND},
        '{CH_SPACE,  1'b0, CHK_QUIET,  ST_FOUND},
        '{"x",       1'b0, CHK_STATUS, ST_MALFORMED},
        '{"z",       1'b1, CHK_QUIET,  ST_FOUND},
        // truncated inside a token
        '{CH_QUOTE,  1'b0, CHK_QUIET,  ST_FOUND},
        '{"a",       1'b1, CHK_STATUS, ST_MALFORMED},
        // truncated inside an escape
        '{CH_QUOTE,  1'b0, CHK_QUIET,  ST_FOUND},
        '{CH_BSLASH, 1'b1, CHK_STATUS, ST_MALFORMED},
        // token with no colon
        '{CH_QUOTE,  1'b0, CHK_QUIET,  ST_FOUND},
        '{CH_QUOTE,  1'b1, CHK_STATUS, ST_NOT_FOUND},
        // colon with no value
        '{CH_QUOTE,  1'b0, CHK_QUIET,  ST_FOUND},
        '{CH_QUOTE,  1'b0, CHK_QUIET,  ST_FOUND},
        '{CH_COLON,  1'b1, CHK_STATUS, ST_MALFORMED},
        // bare value lacking its delimiter
        '{CH_QUOTE,  1'b0, CHK_QUIET,  ST_FOUND},
        '{CH_QUOTE,  1'b0, CHK_QUIET,  ST_FOUND},
        '{CH_COLON,  1'b0, CHK_QUIET,  ST_FOUND},
        '{"1",       1'b1, CHK_MODEL,  ST_FOUND}
    };

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    fjke_in_if  text_ch ();
    fjke_out_if res_ch ();

    flat_json_key_value_extractor_core uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in       (text_ch.sink),
        .o_out      (res_ch.source)
    );

    // predictor copy of key registers and parser state
    logic [63:0] key_lo;
    logic [63:0] key_hi;
    logic [4:0]  key_len;
    t_pmode      pmode;
    logic        key_ok;
    logic [4:0]  tok_len;
    logic        val_started;

    t_res       step_res [$];
    t_res       due_results [$];
    logic [7:0] txt [$];
    int         fails;
    int         bytes_fed;
    logic       src_idle;
    logic       snk_stall;

    initial i_clk = 1'b0;
    always #1 i_clk = ~i_clk;

    function automatic logic ws_char(input logic [7:0] c);
        case (c)
            CH_SPACE, CH_TAB, CH_LF, CH_CR: ws_char = 1'b1;
            default: ws_char = 1'b0;
        endcase
    endfunction

    function automatic logic delim_char(input logic [7:0] c);
        case (c)
            CH_COMMA, CH_RBRACE, CH_RBRACKET: delim_char = 1'b1;
            default: delim_char = 1'b0;
        endcase
    endfunction

    function automatic logic [7:0] key_char(input logic [4:0] idx);
        logic [63:0] word;
        word = idx[3] ? key_hi : key_lo;
        key_char = word[{idx[2:0], 3'b000} +: 8];
    endfunction

    function automatic void restart_text();
        pmode       = PM_OUTSIDE;
        key_ok      = 1'b1;
        tok_len     = 5'd0;
        val_started = 1'b0;
    endfunction

    function automatic void scan_char(input logic [7:0] c);
        if (c == CH_QUOTE) begin
            pmode   = PM_TOKEN;
            tok_len = 5'd0;
            key_ok  = 1'b1;
        end else begin
            pmode = PM_OUTSIDE;
        end
    endfunction

    function automatic void feed_key(input logic [7:0] c);
        if (key_ok && tok_len < key_len && tok_len < KEY_MAX_BYTES && c == key_char(tok_len))
            tok_len = tok_len + 5'd1;
        else
            key_ok = 1'b0;
    endfunction

    function automatic t_res value_beat(input logic [7:0] c);
        value_beat = '{KIND_VALUE, c, ST_FOUND, 1'b0};
    endfunction

    // advance the lookup by one text byte, results land in step_res
    function automatic void lookup_step(input logic [7:0] c, input logic eot);
        t_res       r [2];
        int         n;
        logic       decided;
        logic [1:0] st;
        logic [7:0] v;
        n       = 0;
        decided = 1'b0;
        st      = ST_FOUND;
        step_res.delete();
        case (pmode)
            PM_OUTSIDE: scan_char(c);
            PM_TOKEN: begin
                if (c == CH_BSLASH) begin
                    pmode = PM_TOKEN_ESC;
                end else if (c == CH_QUOTE) begin
                    key_ok = key_ok && (tok_len == key_len);
                    pmode  = PM_AFTER_TOKEN;
                end else begin
                    feed_key(c);
                end
            end
            PM_TOKEN_ESC: begin
                feed_key(c);
                pmode = PM_TOKEN;
            end
            PM_AFTER_TOKEN: begin
                if (!ws_char(c)) begin
                    if (c == CH_COLON) pmode = PM_AFTER_COLON;
                    else scan_char(c);
                end
            end
            PM_AFTER_COLON: begin
                if (!ws_char(c)) begin
                    if (!key_ok) begin
                        scan_char(c);
                    end else begin
                        val_started = 1'b1;
                        if (c == CH_QUOTE) begin
                            pmode = PM_STR_VAL;
                        end else if (delim_char(c)) begin
                            decided = 1'b1;
                            st      = ST_MALFORMED;
                        end else begin
                            r[n] = value_beat(c);
                            n++;
                            pmode = PM_BARE;
                        end
                    end
                end
            end
            PM_STR_VAL: begin
                if (c == CH_BSLASH) begin
                    pmode = PM_STR_ESC;
                end else if (c == CH_QUOTE) begin
                    decided = 1'b1;
                end else begin
                    r[n] = value_beat(c);
                    n++;
                end
            end
            PM_STR_ESC: begin
                case (c)
                    CH_LOW_N: v = CH_LF;
                    CH_LOW_R: v = CH_CR;
                    CH_LOW_T: v = CH_TAB;
                    default:  v = c;
                endcase
                r[n] = value_beat(v);
                n++;
                pmode = PM_STR_VAL;
            end
            PM_BARE: begin
                if (delim_char(c)) begin
                    decided = 1'b1;
                end else if (ws_char(c)) begin
                    pmode = PM_BARE_TAIL;
                end else begin
                    r[n] = value_beat(c);
                    n++;
                end
            end
            PM_BARE_TAIL: begin
                if (!ws_char(c)) begin
                    decided = 1'b1;
                    st      = delim_char(c) ? ST_FOUND : ST_MALFORMED;
                end
            end
            default: ;
        endcase

        // end of text forces a status unless one was already given
        if (!decided && eot && pmode != PM_DONE) begin
            decided = 1'b1;
            st = (pmode == PM_OUTSIDE || pmode == PM_AFTER_TOKEN) ? ST_NOT_FOUND : ST_MALFORMED;
        end
        if (decided) begin
            r[n] = '{KIND_STATUS, 8'h00, st, 1'b0};
            n++;
            pmode = PM_DONE;
        end
        if (eot) restart_text();
        if (n > 0) r[n-1].last = 1'b1;
        for (int k = 0; k < n; k++) step_res.push_back(r[k]);
    endfunction

    function automatic void flag(input string what, input t_res want, input t_res got);
        fails++;
        if (fails <= 10)
            $display("mismatch: %s: expected kind %0d byte %02h status %0d last %0d, ",
                     what, want.kind, want.vbyte, want.st, want.last,
                     "got kind %0d byte %02h status %0d last %0d",
                     got.kind, got.vbyte, got.st, got.last);
    endfunction

    function automatic int idle_len();
        int p;
        p = $urandom_range(0, 99);
        if (p < 75) idle_len = $urandom_range(1, 2);
        else if (p < 95) idle_len = $urandom_range(3, 8);
        else idle_len = $urandom_range(16, 40);
    endfunction

    // one text beat, returns at the edge where it is taken
    task automatic push_byte(input logic [7:0] c, input logic eot);
        int gap;
        gap = (src_idle && $urandom_range(0, 3) == 0) ? idle_len() : 0;
        if (gap > 0) begin
            text_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        text_ch.valid       <= 1'b1;
        text_ch.text_byte   <= c;
        text_ch.end_of_text <= eot;
        @(posedge i_clk);
        while (!text_ch.ready) @(posedge i_clk);
        bytes_fed++;
    endtask

    // wait until every result is in and the parser has gone quiet
    task automatic settle();
        while (due_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_key(input logic [63:0] lo, input logic [63:0] hi, input logic [4:0] len);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= CFG_KEY_FIRST;
        i_cfg_data <= lo;
        @(posedge i_clk);
        i_cfg_idx  <= CFG_KEY_NEXT;
        i_cfg_data <= hi;
        @(posedge i_clk);
        i_cfg_idx  <= CFG_KEY_LEN;
        i_cfg_data <= {59'd0, len};
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        key_lo  = lo;
        key_hi  = hi;
        key_len = len;
    endtask

    // text builders
    function automatic void opt_ws();
        logic [7:0] pick [4];
        int n;
        pick = '{CH_SPACE, CH_TAB, CH_LF, CH_CR};
        if ($urandom_range(0, 2) == 0) begin
            n = $urandom_range(1, 2);
            for (int k = 0; k < n; k++) txt.push_back(pick[$urandom_range(0, 3)]);
        end
    endfunction

    function automatic void put_key_char(input logic [7:0] c);
        if (c == CH_QUOTE || c == CH_BSLASH || $urandom_range(0, 9) == 0)
            txt.push_back(CH_BSLASH);
        txt.push_back(c);
    endfunction

    function automatic void put_key();
        int how;
        int klen;
        int n;
        how  = $urandom_range(0, 9);
        klen = (key_len > KEY_MAX_BYTES) ? KEY_MAX_BYTES : key_len;
        txt.push_back(CH_QUOTE);
        if (how < 5) begin
            for (int k = 0; k < klen; k++) put_key_char(key_char(k[4:0]));
        end else if (how < 6) begin
            n = (klen > 0) ? $urandom_range(0, klen - 1) : 0;
            for (int k = 0; k < n; k++) put_key_char(key_char(k[4:0]));
        end else if (how < 7) begin
            for (int k = 0; k < klen; k++) put_key_char(key_char(k[4:0]));
            put_key_char(8'($urandom_range(0, 255)));
        end else begin
            n = $urandom_range(0, 4);
            for (int k = 0; k < n; k++) put_key_char(8'($urandom_range(0, 255)));
        end
        txt.push_back(CH_QUOTE);
    endfunction

    function automatic void put_string_val();
        logic [7:0] esc [5];
        logic [7:0] c;
        int n;
        esc = '{CH_LOW_N, CH_LOW_R, CH_LOW_T, CH_QUOTE, CH_BSLASH};
        n = $urandom_range(0, 6);
        txt.push_back(CH_QUOTE);
        for (int k = 0; k < n; k++) begin
            if ($urandom_range(0, 4) == 0) begin
                txt.push_back(CH_BSLASH);
                if ($urandom_range(0, 5) == 0) txt.push_back(8'($urandom_range(0, 255)));
                else txt.push_back(esc[$urandom_range(0, 4)]);
            end else begin
                do c = 8'($urandom_range(0, 255)); while (c == CH_QUOTE || c == CH_BSLASH);
                txt.push_back(c);
            end
        end
        txt.push_back(CH_QUOTE);
    endfunction

    function automatic void put_bare_val();
        logic [7:0] c;
        int n;
        n = $urandom_range(1, 5);
        for (int k = 0; k < n; k++) begin
            do c = 8'($urandom_range(0, 255)); while (ws_char(c) || delim_char(c));
            txt.push_back(c);
        end
    endfunction

    // mostly well-formed objects, some noise, truncation and stray bytes
    function automatic void build_text();
        int style;
        int pairs;
        int sel;
        int cut;
        txt.delete();
        style = $urandom_range(0, 19);
        if (style < 2) begin
            cut = $urandom_range(1, 10);
            for (int k = 0; k < cut; k++) txt.push_back(8'($urandom_range(0, 255)));
        end else begin
            txt.push_back("{");
            opt_ws();
            pairs = $urandom_range(1, 4);
            for (int p = 0; p < pairs; p++) begin
                put_key();
                opt_ws();
                if ($urandom_range(0, 19) != 0) txt.push_back(CH_COLON);
                opt_ws();
                sel = $urandom_range(0, 9);
                if (sel < 5) put_string_val();
                else if (sel < 9) put_bare_val();
                else txt.push_back(8'($urandom_range(0, 255)));
                opt_ws();
                if ($urandom_range(0, 9) == 0) txt.push_back(CH_RBRACKET);
                else txt.push_back((p == pairs - 1) ? CH_RBRACE : CH_COMMA);
                opt_ws();
            end
            if (style < 4) begin
                cut = $urandom_range(1, txt.size());
                while (txt.size() > cut) void'(txt.pop_back());
            end else if (style < 5) begin
                txt.insert($urandom_range(0, txt.size()), 8'($urandom_range(0, 255)));
            end
        end
        if ($urandom_range(0, 4) == 0) begin
            cut = $urandom_range(1, 3);
            for (int k = 0; k < cut; k++) txt.push_back(8'($urandom_range(0, 255)));
        end
    endfunction

    task automatic feed_text();
        logic eot;
        for (int k = 0; k < txt.size(); k++) begin
            eot = (k == txt.size() - 1);
            push_byte(txt[k], eot);
            lookup_step(txt[k], eot);
            foreach (step_res[j]) due_results.push_back(step_res[j]);
        end
    endtask

    // result checker
    always @(posedge i_clk) begin : check_side
        t_res got;
        t_res want;
        if (i_rst_n && res_ch.valid && res_ch.ready) begin
            got = '{res_ch.result_kind, res_ch.value_byte, res_ch.status, res_ch.run_last};
            if (due_results.size() == 0) begin
                flag("result with none expected", '0, got);
            end else begin
                want = due_results.pop_front();
                if (got.kind !== want.kind || got.vbyte !== want.vbyte ||
                    got.st !== want.st || got.last !== want.last)
                    flag("wrong result", want, got);
            end
        end
    end

    // result side back-pressure
    initial begin : sink_side
        int hold;
        hold         = 0;
        res_ch.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold > 0) begin
                res_ch.ready <= 1'b0;
                hold--;
            end else begin
                res_ch.ready <= 1'b1;
                if (snk_stall && $urandom_range(0, 3) == 0) hold = idle_len();
            end
        end
    end

    initial begin : watchdog
        #2000000;
        $display("Some tests failed");
        $finish;
    end

    initial begin : stimulus
        logic [63:0] lo;
        logic [63:0] hi;
        logic [4:0]  len;
        int          target;
        fails               = 0;
        bytes_fed           = 0;
        src_idle            = 1'b0;
        snk_stall           = 1'b0;
        i_rst_n             = 1'b0;
        i_cfg_we            = 1'b0;
        i_cfg_idx           = CFG_KEY_FIRST;
        i_cfg_data          = '0;
        text_ch.valid       = 1'b0;
        text_ch.text_byte   = 8'h00;
        text_ch.end_of_text = 1'b0;
        key_lo              = '0;
        key_hi              = '0;
        key_len             = 5'd0;
        restart_text();
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed texts against the empty key
        for (int i = 0; i < DIR_ROWS; i++) begin
            push_byte(dir_tab[i].ch, dir_tab[i].eot);
            lookup_step(dir_tab[i].ch, dir_tab[i].eot);
            case (dir_tab[i].chk)
                CHK_MODEL:  foreach (step_res[j]) due_results.push_back(step_res[j]);
                CHK_STATUS: due_results.push_back('{KIND_STATUS, 8'h00, dir_tab[i].st, 1'b1});
                default: ;
            endcase
        end
        text_ch.valid <= 1'b0;
        settle();

        // random texts under a series of keys
        for (int ph = 0; ph < PHASES; ph++) begin
            lo = {$urandom, $urandom};
            hi = {$urandom, $urandom};
            case (ph)
                0: len = 5'd16;
                1: begin
                    lo  = '1;
                    hi  = '1;
                    len = 5'd16;
                end
                2: begin
                    lo  = '0;
                    hi  = '0;
                    len = 5'd3;
                end
                3: len = 5'd17;
                4: len = 5'd31;
                5: len = 5'd0;
                6: len = 5'($urandom_range(1, 8));
                default: len = 5'($urandom_range(9, 16));
            endcase
            set_key(lo, hi, len);
            target = bytes_fed + PHASE_BYTES;
            while (bytes_fed < target) begin
                src_idle  = ($urandom_range(0, 4) != 0);
                snk_stall = ($urandom_range(0, 4) != 0);
                build_text();
                feed_text();
            end
            text_ch.valid <= 1'b0;
            settle();
        end

        if (fails == 0 && due_results.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
